// ----- sv/c2d_pkg.sv -----
// package: shared constants and types for the 2-d convolution filter
package c2d_pkg;

   // defaults for the top level parameters
   localparam int MAX_KERNEL_DEF      = 5;
   localparam int MAX_WIDTH_DEF       = 1024;
   localparam int COEFF_FRAC_BITS_DEF = 8;

   // fixed field and register widths
   localparam int PIX_W      = 8;
   localparam int COEFF_W    = 16;
   localparam int CIDX_W     = 5;
   localparam int WREG_W     = 11;
   localparam int HREG_W     = 13;
   localparam int KREG_W     = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 13;
   localparam int ROW_W      = 12;
   localparam int HEIGHT_LIMIT = 4096;

   // register reset values
   localparam logic [WREG_W-1:0] WIDTH_RESET  = WREG_W'(1024);
   localparam logic [HREG_W-1:0] HEIGHT_RESET = HREG_W'(1024);
   localparam logic [KREG_W-1:0] KERNEL_RESET = KREG_W'(3);

   // register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WIDTH  = 2'd0,
      CSR_HEIGHT = 2'd1,
      CSR_KERNEL = 2'd2,
      CSR_SPARE  = 2'd3
   } csr_index_type;

   // item commands
   localparam logic CMD_COEFF = 1'b0;
   localparam logic CMD_PIXEL = 1'b1;

endpackage

// ----- sv/conv2d_u8_valid_clamp.sv -----
// top level: streaming 2-d convolution of an 8-bit frame, valid region, clamped
//
//  channel | dir | handshake                 | payload
//  req     | in  | req_tvalid / req_tready   | tuser command, tdata index/coeff/pixel
//  rsp     | out | rsp_tvalid / rsp_tready   | tdata pixel_out, tlast frame_last
//  csr     | in  | csr_we (no handshake)     | csr_index, csr_wdata
//
// one item per clock while rsp is not stalled; a pixel reaches rsp through the stages below
// stages: line store read, window, coefficient select, multiply, row sums, total, clamp
// a stall on rsp freezes every stage at once, so req_tready follows the output register
// reset is synchronous: counters, valid bits and the coefficient table clear
// a write to width, height or kernel restarts the frame; coefficients and stored lines are kept
module conv2d_u8_valid_clamp #(
   parameter int MAX_KERNEL      = c2d_pkg::MAX_KERNEL_DEF,
   parameter int MAX_WIDTH       = c2d_pkg::MAX_WIDTH_DEF,
   parameter int COEFF_FRAC_BITS = c2d_pkg::COEFF_FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // coeff_index[4:0], coeff_value[20:5], pixel_in[28:21], zero fill
   input  logic [31:0]                       req_tdata,
   // command[0]
   input  logic                              req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // pixel_out[7:0]
   output logic [7:0]                        rsp_tdata,
   output logic                              rsp_tlast,
   input  logic                              csr_we,
   input  logic [c2d_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [c2d_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int CW     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int BW     = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
   localparam int KW     = $clog2(MAX_KERNEL + 1);
   localparam int NTAP   = MAX_KERNEL * MAX_KERNEL;
   localparam int IW     = (NTAP > 1) ? $clog2(NTAP) : 1;
   localparam int PROD_W = c2d_pkg::COEFF_W + c2d_pkg::PIX_W + 1;
   localparam int ROWS_W = PROD_W + $clog2(MAX_KERNEL + 1);
   localparam int SUM_W  = ROWS_W + $clog2(MAX_KERNEL + 1);
   localparam int PW     = c2d_pkg::PIX_W;

   // ---------------- configuration registers ----------------
   logic [c2d_pkg::WREG_W-1:0] width_ff;
   logic [c2d_pkg::HREG_W-1:0] height_ff;
   logic [c2d_pkg::KREG_W-1:0] kernel_ff;
   logic                       csr_hit;

   assign csr_hit = csr_we && (csr_index == c2d_pkg::CSR_WIDTH ||
                               csr_index == c2d_pkg::CSR_HEIGHT ||
                               csr_index == c2d_pkg::CSR_KERNEL);

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= c2d_pkg::WIDTH_RESET;
         height_ff <= c2d_pkg::HEIGHT_RESET;
         kernel_ff <= c2d_pkg::KERNEL_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            c2d_pkg::CSR_WIDTH:  width_ff  <= csr_wdata[c2d_pkg::WREG_W-1:0];
            c2d_pkg::CSR_HEIGHT: height_ff <= csr_wdata[c2d_pkg::HREG_W-1:0];
            c2d_pkg::CSR_KERNEL: kernel_ff <= csr_wdata[c2d_pkg::KREG_W-1:0];
            default: ;
         endcase
      end
   end

   // effective frame and kernel sizes after saturation
   logic [CW:0]                w_eff;
   logic [c2d_pkg::ROW_W:0]    h_eff;
   logic [KW-1:0]              k_eff;

   always_comb begin
      int w, h, k;
      w = int'(width_ff);
      h = int'(height_ff);
      k = int'(kernel_ff);
      if (w == 0) w = 1;
      if (w > MAX_WIDTH) w = MAX_WIDTH;
      if (h == 0) h = 1;
      if (h > c2d_pkg::HEIGHT_LIMIT) h = c2d_pkg::HEIGHT_LIMIT;
      if (k == 0) k = 1;
      if (k > MAX_KERNEL) k = MAX_KERNEL;
      if ((k % 2) == 0) k = k - 1;
      w_eff = (CW+1)'(w);
      h_eff = (c2d_pkg::ROW_W+1)'(h);
      k_eff = KW'(k);
   end

   // ---------------- pipeline control ----------------
   logic adv;
   logic rsp_valid_ff;
   logic accept;
   logic in_cmd;
   logic [c2d_pkg::CIDX_W-1:0]  in_idx;
   logic [c2d_pkg::COEFF_W-1:0] in_val;
   logic [PW-1:0]               in_pix;

   // whole pipeline moves unless the output register is stuck
   assign adv        = !rsp_valid_ff || rsp_tready;
   assign req_tready = adv;
   assign accept     = req_tvalid && adv;
   assign in_cmd     = req_tuser;
   assign in_idx     = req_tdata[4:0];
   assign in_val     = req_tdata[20:5];
   assign in_pix     = req_tdata[28:21];

   // ---------------- raster counters ----------------
   logic [CW-1:0]            col_ff, col_in;
   logic [c2d_pkg::ROW_W-1:0] row_ff, row_in;
   logic [BW-1:0]            bank_ff, bank_in;
   logic                     emit_in, last_in;

   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      bank_in = bank_ff;
      emit_in = (int'(row_ff) + 1 >= int'(k_eff)) && (int'(col_ff) + 1 >= int'(k_eff));
      last_in = (int'(row_ff) == int'(h_eff) - 1) && (int'(col_ff) == int'(w_eff) - 1);
      if (int'(col_ff) + 1 >= int'(w_eff)) begin
         col_in = '0;
         if (int'(row_ff) + 1 >= int'(h_eff)) begin
            row_in  = '0;
            bank_in = '0;
         end else begin
            row_in  = row_ff + 1'b1;
            bank_in = (int'(bank_ff) == MAX_KERNEL - 1) ? '0 : bank_ff + 1'b1;
         end
      end else begin
         col_in = col_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || csr_hit) begin
         col_ff  <= '0;
         row_ff  <= '0;
         bank_ff <= '0;
      end else if (accept && in_cmd == c2d_pkg::CMD_PIXEL) begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         bank_ff <= bank_in;
      end
   end

   // ---------------- line store: one bank per source row mod MAX_KERNEL ----------------
   logic [PW-1:0] line_mem [MAX_KERNEL][MAX_WIDTH];
   logic [PW-1:0] rd_ff [MAX_KERNEL];

   always_ff @(posedge clock) begin
      for (int b = 0; b < MAX_KERNEL; b++) begin
         if (accept) begin
            if (in_cmd == c2d_pkg::CMD_PIXEL && int'(bank_ff) == b)
               line_mem[b][col_ff] <= in_pix;
            rd_ff[b] <= line_mem[b][col_ff];
         end
      end
   end

   // stage 1 payload
   logic                        v1_ff;
   logic                        cmd1_ff, emit1_ff, last1_ff;
   logic [c2d_pkg::CIDX_W-1:0]  idx1_ff;
   logic [c2d_pkg::COEFF_W-1:0] val1_ff;
   logic [PW-1:0]               pix1_ff;
   logic [BW-1:0]               bank1_ff;

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else if (adv) v1_ff <= req_tvalid;
      if (adv) begin
         cmd1_ff  <= in_cmd;
         idx1_ff  <= in_idx;
         val1_ff  <= in_val;
         pix1_ff  <= in_pix;
         bank1_ff <= bank_ff;
         emit1_ff <= emit_in;
         last1_ff <= last_in;
      end
   end

   // ---------------- window: row age j, column age a ----------------
   logic [PW-1:0] colv [MAX_KERNEL];
   logic [PW-1:0] win_ff [MAX_KERNEL][MAX_KERNEL];

   always_comb begin
      for (int j = 0; j < MAX_KERNEL; j++) begin
         int b;
         b = int'(bank1_ff) - j;
         if (b < 0) b = b + MAX_KERNEL;
         // the newest row bypasses the bank being written
         colv[j] = (j == 0) ? pix1_ff : rd_ff[BW'(b)];
      end
   end

   logic                        v2_ff;
   logic                        cmd2_ff, emit2_ff, last2_ff;
   logic [c2d_pkg::CIDX_W-1:0]  idx2_ff;
   logic [c2d_pkg::COEFF_W-1:0] val2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
         for (int j = 0; j < MAX_KERNEL; j++)
            for (int a = 0; a < MAX_KERNEL; a++)
               win_ff[j][a] <= '0;
      end else if (adv) begin
         v2_ff <= v1_ff;
         if (v1_ff && cmd1_ff == c2d_pkg::CMD_PIXEL) begin
            for (int j = 0; j < MAX_KERNEL; j++) begin
               win_ff[j][0] <= colv[j];
               for (int a = 1; a < MAX_KERNEL; a++)
                  win_ff[j][a] <= win_ff[j][a-1];
            end
         end
      end
      if (adv) begin
         cmd2_ff  <= cmd1_ff;
         idx2_ff  <= idx1_ff;
         val2_ff  <= val1_ff;
         emit2_ff <= emit1_ff;
         last2_ff <= last1_ff;
      end
   end

   // ---------------- coefficient table, written in item order ----------------
   logic signed [c2d_pkg::COEFF_W-1:0] coef_ff [NTAP];
   logic signed [c2d_pkg::COEFF_W-1:0] csel [MAX_KERNEL][MAX_KERNEL];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NTAP; i++) coef_ff[i] <= '0;
      end else if (adv && v2_ff && cmd2_ff == c2d_pkg::CMD_COEFF &&
                   int'(idx2_ff) < NTAP) begin
         coef_ff[IW'(idx2_ff)] <= val2_ff;
      end
   end

   // age (j,a) is kernel position (k-1-j, k-1-a), flat index row*k+col
   always_comb begin
      for (int j = 0; j < MAX_KERNEL; j++) begin
         for (int a = 0; a < MAX_KERNEL; a++) begin
            int k, map;
            k = int'(k_eff);
            map = (k - 1 - j) * k + (k - 1 - a);
            if (j < k && a < k) csel[j][a] = coef_ff[IW'(map)];
            else csel[j][a] = '0;
         end
      end
   end

   // stage 3: operands for the multipliers
   logic                               v3_ff, last3_ff;
   logic [PW-1:0]                      win3_ff  [MAX_KERNEL][MAX_KERNEL];
   logic signed [c2d_pkg::COEFF_W-1:0] coef3_ff [MAX_KERNEL][MAX_KERNEL];

   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else if (adv) v3_ff <= v2_ff && cmd2_ff == c2d_pkg::CMD_PIXEL && emit2_ff;
      if (adv) begin
         last3_ff <= last2_ff;
         win3_ff  <= win_ff;
         coef3_ff <= csel;
      end
   end

   // stage 4: products
   logic                     v4_ff, last4_ff;
   logic signed [PROD_W-1:0] prod4_ff [MAX_KERNEL][MAX_KERNEL];

   always_ff @(posedge clock) begin
      if (reset) v4_ff <= 1'b0;
      else if (adv) v4_ff <= v3_ff;
      if (adv) begin
         last4_ff <= last3_ff;
         for (int j = 0; j < MAX_KERNEL; j++)
            for (int a = 0; a < MAX_KERNEL; a++)
               prod4_ff[j][a] <= PROD_W'($signed({1'b0, win3_ff[j][a]}) * coef3_ff[j][a]);
      end
   end

   // stage 5: row sums
   logic                     v5_ff, last5_ff;
   logic signed [ROWS_W-1:0] rsum5_ff [MAX_KERNEL];
   logic signed [ROWS_W-1:0] rsum_in  [MAX_KERNEL];

   always_comb begin
      for (int j = 0; j < MAX_KERNEL; j++) begin
         rsum_in[j] = '0;
         for (int a = 0; a < MAX_KERNEL; a++)
            rsum_in[j] = rsum_in[j] + ROWS_W'(prod4_ff[j][a]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) v5_ff <= 1'b0;
      else if (adv) v5_ff <= v4_ff;
      if (adv) begin
         last5_ff <= last4_ff;
         rsum5_ff <= rsum_in;
      end
   end

   // stage 6: window total
   logic                    v6_ff, last6_ff;
   logic signed [SUM_W-1:0] sum6_ff, sum_in;

   always_comb begin
      sum_in = '0;
      for (int j = 0; j < MAX_KERNEL; j++)
         sum_in = sum_in + SUM_W'(rsum5_ff[j]);
   end

   always_ff @(posedge clock) begin
      if (reset) v6_ff <= 1'b0;
      else if (adv) v6_ff <= v5_ff;
      if (adv) begin
         last6_ff <= last5_ff;
         sum6_ff  <= sum_in;
      end
   end

   // output register: floor shift and clamp to 0..255
   logic signed [SUM_W-1:0] shifted;
   logic [PW-1:0]           pix_in;
   logic [PW-1:0]           pix_out_ff;
   logic                    last_out_ff;

   assign shifted = sum6_ff >>> COEFF_FRAC_BITS;

   always_comb begin
      if (sum6_ff < 0) pix_in = '0;
      else if (shifted > SUM_W'(255)) pix_in = '1;
      else pix_in = shifted[PW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (adv) rsp_valid_ff <= v6_ff;
      if (adv) begin
         pix_out_ff  <= pix_in;
         last_out_ff <= last6_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = pix_out_ff;
   assign rsp_tlast  = last_out_ff;

`ifndef NO_ASSERTIONS
   // raster counters stay inside the current frame
   a_col_range: assert property (@(posedge clock) disable iff (reset)
      int'(col_ff) < int'(w_eff))
      else $error("column counter outside frame width");

   a_row_range: assert property (@(posedge clock) disable iff (reset)
      int'(row_ff) < int'(h_eff))
      else $error("row counter outside frame height");

   // bank pointer wraps with the row counter
   a_bank_wrap: assert property (@(posedge clock) disable iff (reset)
      (row_ff == '0) |-> (bank_ff == '0 && int'(bank_ff) < MAX_KERNEL))
      else $error("line bank out of step with row counter");

   // a stalled output freezes the stage feeding it
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |=> $stable(sum6_ff) && $stable(v6_ff))
      else $error("pipeline moved during output stall");
`endif

endmodule

// ----- tb/sv/conv2d_u8_valid_clamp_tb.sv -----
// testbench: conv2d_u8_valid_clamp against a behavioral convolution predictor
`timescale 1ns / 100ps

module conv2d_u8_valid_clamp_tb;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;
   always #4 clock = ~clock;

   // block ports; the inputs are driven to known values from time zero
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;  // coeff_index[4:0], coeff_value[20:5], pixel_in[28:21]
   logic        req_tuser = c2d_pkg::CMD_PIXEL;  // command[0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;       // pixel_out[7:0]
   logic        rsp_tlast;
   logic        csr_we = 1'b0;
   logic [c2d_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [c2d_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   conv2d_u8_valid_clamp u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // one filtered pixel as it should leave the block
   typedef struct {
      logic [7:0] pix;
      logic       last;
   } out_pixel_type;

   out_pixel_type pending_pixels[$];
   int errors = 0;

   // shadow of the block: registers, coefficients, line store, window, position
   logic [c2d_pkg::WREG_W-1:0]         width_reg;
   logic [c2d_pkg::HREG_W-1:0]         height_reg;
   logic [c2d_pkg::KREG_W-1:0]         kernel_reg;
   logic signed [c2d_pkg::COEFF_W-1:0] coeffs[25];
   logic [7:0]                         lines[5][1024];
   logic [7:0]                         win[5][5];
   int                                 col_pos, row_pos;

   // sender and receiver idling: 0 sender light / receiver heavy, 1 swapped, 2 none
   int  idle_mode = 0;
   bit  hold_req = 1'b0;
   bit  hold_taken = 1'b0;
   int  hold_left = 0;

   function automatic int eff_k();
      int k;
      k = kernel_reg;
      if (k == 0) k = 1;
      if (k > 5) k = 5;
      if ((k & 1) == 0) k = k - 1;
      return k;
   endfunction

   function automatic int eff_w();
      int w;
      w = width_reg;
      if (w == 0) w = 1;
      if (w > 1024) w = 1024;
      return w;
   endfunction

   function automatic int eff_h();
      int h;
      h = height_reg;
      if (h == 0) h = 1;
      if (h > c2d_pkg::HEIGHT_LIMIT) h = c2d_pkg::HEIGHT_LIMIT;
      return h;
   endfunction

   // work out what one accepted item does; queues the filtered pixel if any
   task automatic convolve_item(input logic cmd, input logic [4:0] idx,
                                input logic [15:0] val, input logic [7:0] pix,
                                output bit got, output out_pixel_type op);
      int k, w, h, c, r, back;
      longint acc;
      got = 1'b0;
      op.pix = '0;
      op.last = 1'b0;
      if (cmd == c2d_pkg::CMD_COEFF) begin
         // out-of-range indexes fall through silently
         if (idx < 25) coeffs[idx] = val;
         return;
      end
      k = eff_k();
      w = eff_w();
      h = eff_h();
      c = (col_pos >= w) ? 0 : col_pos;
      r = (row_pos >= h) ? 0 : row_pos;
      lines[r % 5][c] = pix;
      for (int m = 0; m < k; m++) begin
         for (int n = 0; n + 1 < k; n++) win[m][n] = win[m][n+1];
         back = k - 1 - m;
         win[m][k-1] = lines[(r + 5 * c2d_pkg::HEIGHT_LIMIT - back) % 5][c];
      end
      if (r + 1 >= k && c + 1 >= k) begin
         acc = 0;
         for (int m = 0; m < k; m++)
            for (int n = 0; n < k; n++)
               acc += longint'(win[m][n]) * longint'(coeffs[m*k+n]);
         // floor by arithmetic shift, then clamp to the pixel range
         if (acc < 0) op.pix = 8'd0;
         else if ((acc >>> 8) > 255) op.pix = 8'd255;
         else op.pix = 8'(acc >>> 8);
         op.last = (r == h - 1 && c == w - 1);
         got = 1'b1;
         pending_pixels.push_back(op);
      end
      if (c + 1 >= w) begin
         col_pos = 0;
         row_pos = (r + 1 >= h) ? 0 : r + 1;
      end else begin
         col_pos = c + 1;
         row_pos = r;
      end
   endtask

   // offer one item, with random sender gaps, and wait for its acceptance
   task automatic send_item(input logic cmd, input logic [4:0] idx,
                            input logic [15:0] val, input logic [7:0] pix,
                            output bit got, output out_pixel_type op);
      int gap;
      gap = 0;
      if ((idle_mode == 0 && $urandom_range(99) < 10) ||
          (idle_mode == 1 && $urandom_range(99) < 71))
         gap = $urandom_range(1, 3);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {3'b000, pix, val, idx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      convolve_item(cmd, idx, val, pix, got, op);
   endtask

   // let everything in flight drain, including coefficient loads that give no pixel
   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   // register write, only called with the block idle
   task automatic csr_write(input c2d_pkg::csr_index_type ix,
                            input logic [c2d_pkg::CSR_DATA_W-1:0] d);
      csr_we    <= 1'b1;
      csr_index <= ix;
      csr_wdata <= d;
      @(posedge clock);
      csr_we <= 1'b0;
      case (ix)
         c2d_pkg::CSR_WIDTH:  width_reg  = d[c2d_pkg::WREG_W-1:0];
         c2d_pkg::CSR_HEIGHT: height_reg = d[c2d_pkg::HREG_W-1:0];
         c2d_pkg::CSR_KERNEL: kernel_reg = d[c2d_pkg::KREG_W-1:0];
         default: ;
      endcase
      // any known register restarts the frame; the spare index does nothing
      if (ix != c2d_pkg::CSR_SPARE) begin
         col_pos = 0;
         row_pos = 0;
      end
      @(posedge clock);
   endtask

   task automatic report(input string what, input out_pixel_type want,
                         input out_pixel_type seen);
      errors++;
      if (errors <= 10)
         $display("%0t %s: expected pix %0d last %0b, got pix %0d last %0b",
                  $realtime, what, want.pix, want.last, seen.pix, seen.last);
   endtask

   // receiver: checks every filtered pixel against the oldest pending one
   always @(posedge clock) begin
      out_pixel_type want, seen;
      int pct;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen.pix  = rsp_tdata;
         seen.last = rsp_tlast;
         if (pending_pixels.size() == 0) begin
            want.pix = 'x;
            want.last = 'x;
            report("unexpected pixel", want, seen);
         end else begin
            want = pending_pixels.pop_front();
            if (seen.pix !== want.pix || seen.last !== want.last)
               report("pixel mismatch", want, seen);
         end
      end
      // one long hold-off so the pipeline fills and back-pressures the input
      if (hold_req && !hold_taken) begin
         hold_taken = 1'b1;
         hold_left = 400;
      end
      pct = (idle_mode == 0) ? 71 : (idle_mode == 1) ? 10 : 0;
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= pct);
      end
   end

   // directed rows: 3x3 frames with a 3x3 kernel
   typedef struct {
      logic        cmd;
      logic [4:0]  idx;
      logic [15:0] val;
      logic [7:0]  pix;
      bit          chk;
      logic [7:0]  e_pix;
      logic        e_last;
   } dir_row_type;

   localparam int N_DIR = 22;
   dir_row_type dir_rows[N_DIR] = '{
      // identity kernel: center weight 1.0
      '{c2d_pkg::CMD_COEFF, 5'd4,  16'h0100, 8'd0,   1'b0, 8'd0,   1'b0},
      // index past the table is dropped
      '{c2d_pkg::CMD_COEFF, 5'd25, 16'h7FFF, 8'd0,   1'b0, 8'd0,   1'b0},
      '{c2d_pkg::CMD_COEFF, 5'd31, 16'hFFFF, 8'd0,   1'b0, 8'd0,   1'b0},
      '{c2d_pkg::CMD_PIXEL, 5'd0,  16'h0000, 8'd0,   1'b0, 8'd0,   1'b0},
      '{c2d_pkg::CMD_PIXEL, 5'd0,  16'h0000, 8'd1,   1'b0, 8'd0,   1'b0},
      '{c2d_pkg::CMD_PIXEL, 5'd0,  16'h0000, 8'd2,   1'b0, 8'd0,   1'b0},
      '{c2d_pkg::CMD_PIXEL, 5'd0,  16'h0000, 8'd3,   1'b0, 8'd0,   1'b0},
      '{c2d_pkg::CMD_PIXEL, 5'd31, 16'hFFFF, 8'd255, 1'b0, 8'd0,   1'b0},
      '{c2d_pkg::CMD_PIXEL, 5'd0,  16'h0000, 8'd5,   1'b0, 8'd0,   1'b0},
      '{c2d_pkg::CMD_PIXEL, 5'd0,  16'h0000, 8'd6,   1'b0, 8'd0,   1'b0},
      '{c2d_pkg::CMD_PIXEL, 5'd0,  16'h0000, 8'd7,   1'b0, 8'd0,   1'b0},
      '{c2d_pkg::CMD_PIXEL, 5'd0,  16'h0000, 8'd8,   1'b1, 8'd255, 1'b1},
      // most negative corner weight drives the sum below zero
      '{c2d_pkg::CMD_COEFF, 5'd0,  16'h8000, 8'd255, 1'b0, 8'd0,   1'b0},
      '{c2d_pkg::CMD_PIXEL, 5'd0,  16'h0000, 8'd255, 1'b0, 8'd0,   1'b0},
      '{c2d_pkg::CMD_PIXEL, 5'd0,  16'h0000, 8'd255, 1'b0, 8'd0,   1'b0},
      '{c2d_pkg::CMD_PIXEL, 5'd0,  16'h0000, 8'd255, 1'b0, 8'd0,   1'b0},
      '{c2d_pkg::CMD_PIXEL, 5'd0,  16'h0000, 8'd255, 1'b0, 8'd0,   1'b0},
      '{c2d_pkg::CMD_PIXEL, 5'd0,  16'h0000, 8'd255, 1'b0, 8'd0,   1'b0},
      '{c2d_pkg::CMD_PIXEL, 5'd0,  16'h0000, 8'd255, 1'b0, 8'd0,   1'b0},
      '{c2d_pkg::CMD_PIXEL, 5'd0,  16'h0000, 8'd255, 1'b0, 8'd0,   1'b0},
      '{c2d_pkg::CMD_PIXEL, 5'd0,  16'h0000, 8'd255, 1'b0, 8'd0,   1'b0},
      '{c2d_pkg::CMD_PIXEL, 5'd0,  16'h0000, 8'd255, 1'b1, 8'd0,   1'b1}
   };

   // stimulus
   initial begin
      bit            got;
      out_pixel_type op, typed;
      int            rand_items, n_pix, n_coef, area;
      logic [4:0]    cidx;
      logic [15:0]   cval;

      width_reg  = c2d_pkg::WIDTH_RESET;
      height_reg = c2d_pkg::HEIGHT_RESET;
      kernel_reg = c2d_pkg::KERNEL_RESET;
      foreach (coeffs[i]) coeffs[i] = '0;
      foreach (lines[i, j]) lines[i][j] = '0;
      foreach (win[i, j]) win[i][j] = '0;
      col_pos = 0;
      row_pos = 0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table, 3x3 frame
      csr_write(c2d_pkg::CSR_WIDTH, 13'd3);
      csr_write(c2d_pkg::CSR_HEIGHT, 13'd3);
      csr_write(c2d_pkg::CSR_KERNEL, 13'd3);
      foreach (dir_rows[i]) begin
         send_item(dir_rows[i].cmd, dir_rows[i].idx, dir_rows[i].val, dir_rows[i].pix,
                   got, op);
         if (dir_rows[i].chk) begin
            typed.pix  = dir_rows[i].e_pix;
            typed.last = dir_rows[i].e_last;
            if (!got || op.pix !== typed.pix || op.last !== typed.last)
               report("directed row", typed, op);
         end
      end
      drain();

      // widest row: width register overflows to the maximum, 1x1 kernel
      csr_write(c2d_pkg::CSR_WIDTH, 13'd2047);
      csr_write(c2d_pkg::CSR_HEIGHT, 13'd1);
      csr_write(c2d_pkg::CSR_KERNEL, 13'd1);
      csr_write(c2d_pkg::CSR_SPARE, 13'h1FFF);
      send_item(c2d_pkg::CMD_COEFF, 5'd0, 16'h0100, 8'd0, got, op);
      for (int i = 0; i < 1024; i++)
         send_item(c2d_pkg::CMD_PIXEL, 5'($urandom), 16'($urandom), 8'($urandom),
                   got, op);
      drain();

      // tallest column: height saturates, zero width and kernel seven
      csr_write(c2d_pkg::CSR_WIDTH, 13'd0);
      csr_write(c2d_pkg::CSR_HEIGHT, 13'h1FFF);
      csr_write(c2d_pkg::CSR_KERNEL, 13'd0);
      for (int i = 0; i < 20; i++)
         send_item(c2d_pkg::CMD_PIXEL, 5'd0, 16'd0, 8'($urandom), got, op);
      drain();
      csr_write(c2d_pkg::CSR_KERNEL, 13'd7);
      csr_write(c2d_pkg::CSR_WIDTH, 13'd6);
      csr_write(c2d_pkg::CSR_HEIGHT, 13'd0);
      for (int i = 0; i < 8; i++)
         send_item(c2d_pkg::CMD_PIXEL, 5'd0, 16'd0, 8'($urandom), got, op);
      drain();

      // random frames with random kernels and registers
      rand_items = 0;
      while (rand_items < 330) begin
         idle_mode = (rand_items < 110) ? 0 : (rand_items < 220) ? 1 : 2;
         if (rand_items > 40) hold_req = 1'b1;
         if ($urandom_range(99) < 70)
            csr_write(c2d_pkg::CSR_WIDTH,
                      ($urandom_range(99) < 10) ? 13'($urandom)
                                                : 13'($urandom_range(0, 12)));
         if ($urandom_range(99) < 70)
            csr_write(c2d_pkg::CSR_HEIGHT,
                      ($urandom_range(99) < 10) ? 13'($urandom)
                                                : 13'($urandom_range(0, 9)));
         if ($urandom_range(99) < 70)
            csr_write(c2d_pkg::CSR_KERNEL, 13'($urandom_range(0, 7)));
         if ($urandom_range(99) < 5) csr_write(c2d_pkg::CSR_SPARE, 13'($urandom));

         n_coef = $urandom_range(0, 25);
         for (int i = 0; i < n_coef; i++) begin
            cidx = ($urandom_range(99) < 85) ? 5'($urandom_range(0, 24)) : 5'($urandom);
            // mostly moderate weights so results stay off the clamp rails
            cval = ($urandom_range(99) < 80) ? 16'($urandom_range(0, 383) - 128)
                                             : 16'($urandom);
            send_item(c2d_pkg::CMD_COEFF, cidx, cval, 8'($urandom), got, op);
            rand_items++;
         end

         area = eff_w() * eff_h();
         n_pix = (area > 80) ? 80 : area * $urandom_range(1, 2);
         for (int i = 0; i < n_pix; i++) begin
            // occasional coefficient change in the middle of a frame
            if ($urandom_range(99) < 3) begin
               send_item(c2d_pkg::CMD_COEFF, 5'($urandom), 16'($urandom), 8'($urandom),
                         got, op);
               rand_items++;
            end
            send_item(c2d_pkg::CMD_PIXEL, 5'($urandom), 16'($urandom), 8'($urandom),
                      got, op);
            rand_items++;
         end
         drain();
      end

      // everything delivered; give the pipeline a last look for strays
      idle_mode = 2;
      repeat (20) @(posedge clock);
      if (errors == 0 && pending_pixels.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // run limit
   initial begin
      #5ms;
      $display("FAILURE");
      $finish;
   end

endmodule
